// File: hw/rtl/nlt_pkg.sv
// ----------------------------------------------------------------------------
// nlt_pkg
// Shared types and constants of the neighbor liveness table.
// ----------------------------------------------------------------------------
package nlt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W      = 32;
    localparam int SEQ_W       = 16;
    localparam int TICK_W      = 32;
    localparam int TMO_W       = 16;
    localparam int COUNT_FW    = 6;

    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'b1;

    localparam logic OP_HELLO = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd10;

    typedef enum logic [2:0] {
        ST_REFRESHED = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_SELF      = 3'd3,
        ST_TICK      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        K_HELLO = 2'd0,
        K_TICK  = 2'd1,
        K_SELF  = 2'd2
    } t_kind;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] sender_address;
        logic [SEQ_W-1:0]  sequence_number;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [COUNT_FW-1:0] table_size;
        logic [COUNT_FW-1:0] removed_count;
    } t_out_item;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [TICK_W-1:0] heard;
    } t_entry;

endpackage

// File: hw/rtl/nlt_front.sv
// ----------------------------------------------------------------------------
// nlt_front
// Request intake: decodes the operation and flags hellos from this node.
// ----------------------------------------------------------------------------
module nlt_front (
    input  logic                  start,
    output logic                  busy,
    input  nlt_pkg::t_in_item     i_item,
    input  logic [31:0]           i_own_address,
    input  logic                  i_q_full,
    output logic                  o_push,
    output nlt_pkg::t_cmd         o_cmd
);
    import nlt_pkg::*;

    t_kind kind;

    always_comb begin
        if (i_item.operation == OP_TICK) begin
            kind = K_TICK;
        end else if (i_item.sender_address == i_own_address) begin
            kind = K_SELF;
        end else begin
            kind = K_HELLO;
        end
    end

    assign busy       = i_q_full;
    assign o_push     = start && !i_q_full;
    assign o_cmd.kind = kind;
    assign o_cmd.addr = i_item.sender_address;
    assign o_cmd.seq  = i_item.sequence_number;

endmodule

// File: hw/rtl/nlt_fifo.sv
// ----------------------------------------------------------------------------
// nlt_fifo
// Short command queue between request intake and the table engine.
// ----------------------------------------------------------------------------
module nlt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nlt_pkg::t_cmd  i_data,
    input  logic           i_pop,
    output nlt_pkg::t_cmd  o_data,
    output logic           o_full,
    output logic           o_empty
);
    import nlt_pkg::*;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_fill;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_slot[r_rd_ptr];
    assign o_full  = (r_fill == QCNT_W'(QDEPTH));
    assign o_empty = (r_fill == '0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command queue pushed while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command queue popped while empty");
`endif

endmodule

// File: hw/rtl/nlt_back.sv
// ----------------------------------------------------------------------------
// nlt_back
// Table engine: walks the neighbor table for hellos and timeout sweeps.
// ----------------------------------------------------------------------------
module nlt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [15:0]          i_timeout_ticks,
    input  nlt_pkg::t_cmd        i_cmd,
    input  logic                 i_q_empty,
    output logic                 o_pop,
    output logic                 o_done,
    output nlt_pkg::t_out_item   o_result
);
    import nlt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_HSRCH,
        S_TRD,
        S_TCHK,
        S_TCP,
        S_TNEXT
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pidx, n_pidx;
    logic [CNT_W-1:0]  r_removed, n_removed;
    logic              r_done, n_done;
    t_out_item         r_res, n_res;

    t_entry            r_mem [TABLE_DEPTH];
    t_entry            r_rdata;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    t_entry            wr_data;

    logic [IDX_W-1:0]  last_idx;
    logic [TICK_W-1:0] age;
    logic              expired;

    assign last_idx = IDX_W'(r_count - 1'b1);
    assign age      = r_tick - r_rdata.heard;
    assign expired  = age > TICK_W'(i_timeout_ticks);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_idx];
        end
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_count   = r_count;
        n_tick    = r_tick;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_removed = r_removed;
        n_done    = 1'b0;
        n_res     = r_res;
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        rd_idx    = r_idx;
        wr_en     = 1'b0;
        wr_idx    = r_idx;
        wr_data   = r_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_removed = '0;
                n_pend    = 1'b0;
                unique case (r_cmd.kind)
                    K_SELF: begin
                        n_done         = 1'b1;
                        n_res.status   = ST_SELF;
                        n_state        = S_IDLE;
                    end
                    K_TICK: begin
                        n_tick = r_tick + 1'b1;
                        if (r_count == '0) begin
                            n_done       = 1'b1;
                            n_res.status = ST_TICK;
                            n_state      = S_IDLE;
                        end else begin
                            n_idx   = last_idx;
                            n_state = S_TRD;
                        end
                    end
                    K_HELLO: begin
                        if (r_count == '0) begin
                            // empty table: append at slot zero
                            wr_en        = 1'b1;
                            wr_idx       = '0;
                            wr_data      = '{addr: r_cmd.addr, seq: r_cmd.seq, heard: r_tick};
                            n_count      = r_count + 1'b1;
                            n_done       = 1'b1;
                            n_res.status = ST_INSERTED;
                            n_state      = S_IDLE;
                        end else begin
                            n_idx   = '0;
                            n_state = S_HSRCH;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_HSRCH: begin
                // read one entry a cycle, compare the one read the cycle before
                if (r_pend && (r_rdata.addr == r_cmd.addr)) begin
                    wr_en        = 1'b1;
                    wr_idx       = r_pidx;
                    wr_data      = '{addr: r_cmd.addr, seq: r_cmd.seq, heard: r_tick};
                    n_done       = 1'b1;
                    n_res.status = ST_REFRESHED;
                    n_state      = S_IDLE;
                end else if (r_pend && (r_pidx == last_idx)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_count < CNT_W'(TABLE_DEPTH)) begin
                        wr_en        = 1'b1;
                        wr_idx       = IDX_W'(r_count);
                        wr_data      = '{addr: r_cmd.addr, seq: r_cmd.seq, heard: r_tick};
                        n_count      = r_count + 1'b1;
                        n_res.status = ST_INSERTED;
                    end else begin
                        n_res.status = ST_FULL;
                    end
                end else begin
                    rd_en  = 1'b1;
                    rd_idx = r_idx;
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_TRD: begin
                rd_en   = 1'b1;
                rd_idx  = r_idx;
                n_state = S_TCHK;
            end
            S_TCHK: begin
                if (expired) begin
                    n_removed = r_removed + 1'b1;
                    if (r_idx == last_idx) begin
                        n_count = r_count - 1'b1;
                        n_state = S_TNEXT;
                    end else begin
                        // fetch the last entry to fill the hole
                        rd_en   = 1'b1;
                        rd_idx  = last_idx;
                        n_state = S_TCP;
                    end
                end else begin
                    n_state = S_TNEXT;
                end
            end
            S_TCP: begin
                wr_en   = 1'b1;
                wr_idx  = r_idx;
                wr_data = r_rdata;
                n_count = r_count - 1'b1;
                n_state = S_TNEXT;
            end
            S_TNEXT: begin
                if (r_idx == '0) begin
                    n_done       = 1'b1;
                    n_res.status = ST_TICK;
                    n_state      = S_IDLE;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = S_TRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.table_size    = COUNT_FW'(n_count);
        n_res.removed_count = COUNT_FW'(n_removed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_tick    <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_pidx    <= '0;
            r_removed <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_tick    <= n_tick;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_pidx    <= n_pidx;
            r_removed <= n_removed;
            r_done    <= n_done;
        end
        r_cmd <= n_cmd;
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("neighbor count above table depth");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");
    a_insert_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_INSERTED)) |-> (o_result.table_size != '0))
        else $error("insert reported with empty table");
    a_copy_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TCP) |=> (r_count == $past(r_count) - 1'b1))
        else $error("swap removal did not shrink the table");
`endif

endmodule

// File: hw/rtl/neighbor_liveness_table_unit.sv
// ----------------------------------------------------------------------------
// neighbor_liveness_table_unit
// Hello/keepalive neighbor table with a tick clock and timeout sweep.
// ----------------------------------------------------------------------------
// A request passes the queue and the engine's idle and dispatch states; a self
// hello or any request on an empty table ends there, a hello searches the
// table entry by entry and a tick sweeps it from the last entry down. The
// engine works one request at a time; a two-deep queue takes requests
// meanwhile. Results are one-cycle strobes on o_done and cannot be held off.
// Reset clears count, tick clock, queue and state registers; table is not cleared.
module neighbor_liveness_table_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  nlt_pkg::t_in_item      i_cmd,
    output logic                   o_done,
    output nlt_pkg::t_out_item     o_result,
    input  logic                   i_cfg_we,
    input  logic [0:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    import nlt_pkg::*;

    logic [ADDR_W-1:0] r_own_address;
    logic [TMO_W-1:0]  r_timeout_ticks;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address   <= '0;
            r_timeout_ticks <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OWN_ADDRESS: r_own_address   <= i_cfg_data;
                CFG_TIMEOUT:     r_timeout_ticks <= i_cfg_data[TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    nlt_front u_front (
        .start         (start),
        .busy          (busy),
        .i_item        (i_cmd),
        .i_own_address (r_own_address),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    nlt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    nlt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_timeout_ticks (r_timeout_ticks),
        .i_cmd           (q_out),
        .i_q_empty       (q_empty),
        .o_pop           (q_pop),
        .o_done          (o_done),
        .o_result        (o_result)
    );

endmodule
